// ----- sv/learned_event_table_assert.svh -----
// assertion macros for the learned event table
// used by the top level only, no other dependencies
`ifndef LEARNED_EVENT_TABLE_ASSERT_SVH
`define LEARNED_EVENT_TABLE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define LET_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define LET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/let_pkg.sv -----
// shared types and constants for the learned event table
// no dependencies
package let_pkg;

    localparam int MAX_EVENTS_DEF     = 32;
    localparam int VARS_PER_EVENT_DEF = 8;

    typedef enum logic [3:0] {
        OP_LEARN     = 4'd0,
        OP_LOOKUP    = 4'd1,
        OP_READ_EV   = 4'd2,
        OP_ERASE_IDX = 4'd3,
        OP_ERASE_EV  = 4'd4,
        OP_ERASE_ALL = 4'd5,
        OP_READ_VAR  = 4'd6,
        OP_WRITE_VAR = 4'd7,
        OP_READ_ALL  = 4'd8
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_SCAN,
        S_POST,
        S_SHIFT_EV,
        S_SHIFT_VAR,
        S_ERASED,
        S_EVOUT,
        S_VRD,
        S_VOUT
    } t_state;

endpackage

// ----- sv/let_in_if.sv -----
// request channel of the learned event table
// no dependencies
interface let_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [31:0] event_code;
    logic [7:0]  entry_index;
    logic [7:0]  var_index;
    logic [7:0]  var_value;

    modport source (
        output valid, opcode, event_code, entry_index, var_index, var_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, event_code, entry_index, var_index, var_value,
        output ready
    );
endinterface

// ----- sv/let_out_if.sv -----
// response channel of the learned event table
// no dependencies
interface let_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  found_index;
    logic [31:0] event_out;
    logic [7:0]  var_out;
    logic        last;

    modport source (
        output valid, status, found_index, event_out, var_out, last,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, event_out, var_out, last,
        output ready
    );
endinterface

// ----- sv/learned_event_table.sv -----
// learned event table top level: sequencer, event ram, variable ram, match unit
// depends on let_pkg, let_in_if, let_out_if, let_ram, let_cmp and the assert header
//
//   channel   direction  handshake      word
//   i_in      in         valid/ready    opcode, event_code, entry_index, var_index, var_value
//   o_out     out        valid/ready    status, found_index, event_out, var_out, last
//
// after reset the variable ram is zeroed one cell a cycle, with i_in.ready low
// one request at a time; ready only in idle. ops settled at decode register their word
// from the decode state; read event goes via S_EVOUT, read variable via S_VRD and S_VOUT
// lookup / learn scan the event ram one entry a cycle
// erase by index shifts later entries, then their variable rows, through the ram read ports;
// erase by event scans for the hit first, then does the same shift
// read all variables gives VARS words via S_VRD and S_VOUT; o_out stalls hold the sequencer
`include "learned_event_table_assert.svh"

module learned_event_table #(
    parameter int MAX_EVENTS     = let_pkg::MAX_EVENTS_DEF,
    parameter int VARS_PER_EVENT = let_pkg::VARS_PER_EVENT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    let_in_if.sink    i_in,
    let_out_if.source o_out
);
    import let_pkg::*;

    // widths derived from the table geometry
    localparam int VC    = MAX_EVENTS * VARS_PER_EVENT;
    localparam int EV_AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int VAW   = (VC > 1) ? $clog2(VC) : 1;
    localparam int VCW   = $clog2(VC + 1);
    localparam int CW    = $clog2(MAX_EVENTS + 1);
    localparam int VSW   = (VARS_PER_EVENT > 1) ? $clog2(VARS_PER_EVENT) : 1;
    localparam logic [VCW-1:0] VSTEP    = VCW'(VARS_PER_EVENT);
    localparam logic [VAW-1:0] CLR_LAST = VAW'(VC - 1);
    localparam logic [VSW-1:0] VSEL_LAST = VSW'(VARS_PER_EVENT - 1);

    // sequencer state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [VAW-1:0]  r_clr, n_clr;
    // sweep: issue pointer, end bound, pending write/compare slot
    logic [VCW-1:0]  r_src, n_src;
    logic [VCW-1:0]  r_end, n_end;
    logic            r_wv, n_wv;
    logic [VCW-1:0]  r_wa, n_wa;
    logic            r_hit, n_hit;
    logic [CW-1:0]   r_hit_idx, n_hit_idx;
    logic [VSW-1:0]  r_vsel, n_vsel;

    // latched request word
    t_opcode         r_op;
    logic [31:0]     r_code;
    logic [7:0]      r_ei;
    logic [7:0]      r_vi;
    logic [7:0]      r_val;

    // output register
    logic            r_o_vld;
    t_status         r_o_status;
    logic [4:0]      r_o_idx;
    logic [31:0]     r_o_event;
    logic [7:0]      r_o_var;
    logic            r_o_last;

    // result being produced this cycle
    logic            want, emit, out_free;
    t_status         e_status;
    logic [4:0]      e_idx;
    logic [31:0]     e_event;
    logic [7:0]      e_var;
    logic            e_last;

    // ram ports
    logic              ev_we, ev_re;
    logic [EV_AW-1:0]  ev_waddr, ev_raddr;
    logic [31:0]       ev_wdata, ev_rdata;
    logic              var_we, var_re;
    logic [VAW-1:0]    var_waddr, var_raddr;
    logic [7:0]        var_wdata, var_rdata;

    logic              accept, match, issue, sweep_done, entry_ok, var_ok;
    logic [VCW-1:0]    step;
    logic [VAW-1:0]    vaddr;

    let_ram #(.WIDTH(32), .DEPTH(MAX_EVENTS)) u_ev_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wdata),
        .i_re    (ev_re),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    let_ram #(.WIDTH(8), .DEPTH(VC)) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_waddr (var_waddr),
        .i_wdata (var_wdata),
        .i_re    (var_re),
        .i_raddr (var_raddr),
        .o_rdata (var_rdata)
    );

    // one comparator shared by every scan step
    let_cmp u_cmp (
        .i_stored (ev_rdata),
        .i_query  (r_code),
        .o_match  (match)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_o_vld || o_out.ready;
    assign emit       = want && out_free;

    // bounds are strict: entry index < count, variable index < VARS_PER_EVENT
    assign entry_ok = (r_ei < 8'(r_count));
    assign var_ok   = entry_ok && (r_vi < 8'(VARS_PER_EVENT));

    // sweep helpers, shared by scan and both shift phases
    assign issue      = (r_src < r_end);
    assign sweep_done = !r_wv && !issue;
    assign step       = (r_state == S_SHIFT_VAR) ? VSTEP : VCW'(1);
    assign vaddr      = VAW'(VCW'(r_ei) * VSTEP + VCW'(r_vsel));

    assign o_out.valid       = r_o_vld;
    assign o_out.status      = r_o_status;
    assign o_out.found_index = r_o_idx;
    assign o_out.event_out   = r_o_event;
    assign o_out.var_out     = r_o_var;
    assign o_out.last        = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_wv    <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_wv    <= n_wv;
            if (emit) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_end     <= n_end;
        r_wa      <= n_wa;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_vsel    <= n_vsel;
        if (accept) begin
            r_op   <= t_opcode'(i_in.opcode);
            r_code <= i_in.event_code;
            r_ei   <= i_in.entry_index;
            r_vi   <= i_in.var_index;
            r_val  <= i_in.var_value;
        end
        if (emit) begin
            r_o_status <= e_status;
            r_o_idx    <= e_idx;
            r_o_event  <= e_event;
            r_o_var    <= e_var;
            r_o_last   <= e_last;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_clr     = r_clr;
        n_src     = r_src;
        n_end     = r_end;
        n_wv      = r_wv;
        n_wa      = r_wa;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_vsel    = r_vsel;

        ev_we     = 1'b0;
        ev_waddr  = r_wa[EV_AW-1:0];
        ev_wdata  = ev_rdata;
        ev_re     = 1'b0;
        ev_raddr  = r_src[EV_AW-1:0];
        var_we    = 1'b0;
        var_waddr = r_wa[VAW-1:0];
        var_wdata = var_rdata;
        var_re    = 1'b0;
        var_raddr = r_src[VAW-1:0];

        want     = 1'b0;
        e_status = ST_OK;
        e_idx    = '0;
        e_event  = '0;
        e_var    = '0;
        e_last   = 1'b1;

        unique case (r_state) inside
            S_CLEAR: begin
                // zero the variable ram after reset
                var_we    = 1'b1;
                var_waddr = r_clr;
                var_wdata = '0;
                n_clr     = r_clr + VAW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_vsel  = VSW'(i_in.var_index);
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (r_op) inside
                    OP_LEARN, OP_LOOKUP, OP_ERASE_EV: begin
                        if ((r_op == OP_LEARN) && (r_count >= CW'(MAX_EVENTS))) begin
                            want     = 1'b1;
                            e_status = ST_FULL;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            // start a scan over the valid entries
                            n_src   = '0;
                            n_end   = VCW'(r_count);
                            n_wv    = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    OP_READ_EV: begin
                        if (entry_ok) begin
                            ev_re    = 1'b1;
                            ev_raddr = r_ei[EV_AW-1:0];
                            n_state  = S_EVOUT;
                        end else begin
                            want     = 1'b1;
                            e_status = ST_RANGE;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    OP_ERASE_IDX: begin
                        if (entry_ok) begin
                            n_hit_idx = CW'(r_ei);
                            n_src     = VCW'(r_ei) + VCW'(1);
                            n_end     = VCW'(r_count);
                            n_wv      = 1'b0;
                            n_state   = S_SHIFT_EV;
                        end else begin
                            want     = 1'b1;
                            e_status = ST_RANGE;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    OP_ERASE_ALL: begin
                        want = 1'b1;
                        if (out_free) begin
                            n_count = '0;
                            n_state = S_IDLE;
                        end
                    end
                    OP_READ_VAR, OP_READ_ALL: begin
                        if ((r_op == OP_READ_VAR) ? var_ok : entry_ok) begin
                            if (r_op == OP_READ_ALL) begin
                                n_vsel = '0;
                            end
                            n_state = S_VRD;
                        end else begin
                            want     = 1'b1;
                            e_status = ST_RANGE;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    OP_WRITE_VAR: begin
                        want = 1'b1;
                        if (var_ok) begin
                            e_idx = 5'(r_ei);
                            if (out_free) begin
                                var_we    = 1'b1;
                                var_waddr = vaddr;
                                var_wdata = r_val;
                            end
                        end else begin
                            e_status = ST_RANGE;
                        end
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        // unused opcodes
                        want     = 1'b1;
                        e_status = ST_RANGE;
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // read one entry a cycle, compare the one read last cycle
                ev_re = issue;
                n_wv  = issue;
                n_wa  = r_src;
                if (issue) begin
                    n_src = r_src + VCW'(1);
                end
                if (r_wv && match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = CW'(r_wa);
                    n_wv      = 1'b0;
                    n_state   = S_POST;
                end else if (sweep_done) begin
                    n_hit   = 1'b0;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                unique case (r_op)
                    OP_LEARN: begin
                        want  = 1'b1;
                        e_idx = r_hit ? 5'(r_hit_idx) : 5'(r_count);
                        if (out_free) begin
                            if (!r_hit) begin
                                // append at the end of the table
                                ev_we    = 1'b1;
                                ev_waddr = r_count[EV_AW-1:0];
                                ev_wdata = r_code;
                                n_count  = r_count + CW'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_ERASE_EV: begin
                        if (r_hit) begin
                            n_src   = VCW'(r_hit_idx) + VCW'(1);
                            n_end   = VCW'(r_count);
                            n_wv    = 1'b0;
                            n_state = S_SHIFT_EV;
                        end else begin
                            want     = 1'b1;
                            e_status = ST_NOT_FOUND;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    default: begin
                        // lookup
                        want = 1'b1;
                        if (r_hit) begin
                            e_idx = 5'(r_hit_idx);
                        end else begin
                            e_status = ST_NOT_FOUND;
                        end
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SHIFT_EV, S_SHIFT_VAR: begin
                // copy source to source - step, one word a cycle
                if (r_state == S_SHIFT_EV) begin
                    ev_re = issue;
                    ev_we = r_wv;
                end else begin
                    var_re = issue;
                    var_we = r_wv;
                end
                n_wv = issue;
                n_wa = VCW'(r_src - step);
                if (issue) begin
                    n_src = r_src + VCW'(1);
                end
                if (sweep_done) begin
                    if (r_state == S_SHIFT_EV) begin
                        // move the variable rows the same way
                        n_src   = VCW'((VCW'(r_hit_idx) + VCW'(1)) * VSTEP);
                        n_end   = VCW'(VCW'(r_count) * VSTEP);
                        n_state = S_SHIFT_VAR;
                    end else begin
                        n_state = S_ERASED;
                    end
                end
            end
            S_ERASED: begin
                want  = 1'b1;
                e_idx = 5'(r_hit_idx);
                if (out_free) begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_EVOUT: begin
                want    = 1'b1;
                e_idx   = 5'(r_ei);
                e_event = ev_rdata;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_VRD: begin
                var_re    = 1'b1;
                var_raddr = vaddr;
                n_state   = S_VOUT;
            end
            S_VOUT: begin
                want   = 1'b1;
                e_idx  = 5'(r_ei);
                e_var  = var_rdata;
                e_last = (r_op != OP_READ_ALL) || (r_vsel == VSEL_LAST);
                if (out_free) begin
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_vsel  = r_vsel + VSW'(1);
                        n_state = S_VRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    `LET_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_EVENTS), "entry count beyond table size")
    `LET_ASSERT_IMPL(a_quiet_clear, i_clk, i_rst_n, r_state == S_CLEAR, !r_o_vld && !ev_we, "activity during clearing pass")
    `LET_ASSERT_IMPL(a_full_only, i_clk, i_rst_n, emit && (e_status == ST_FULL), r_count == CW'(MAX_EVENTS), "table full reported below capacity")
    `LET_ASSERT_NEXT(a_erase_dec, i_clk, i_rst_n, (r_state == S_ERASED) && out_free, r_count == $past(r_count) - CW'(1), "erase did not drop the count")

endmodule

// ----- sv/let_ram.sv -----
// generic single write port ram with registered read and read enable
// no dependencies
module let_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- sv/let_cmp.sv -----
// event match unit: full word when the node half is nonzero, else low half only
// no dependencies
module let_cmp (
    input  logic [31:0] i_stored,
    input  logic [31:0] i_query,
    output logic        o_match
);
    logic long_query;

    assign long_query = (i_query[31:16] != 16'd0);

    always_comb begin
        if (long_query) begin
            o_match = (i_stored == i_query);
        end else begin
            o_match = (i_stored[15:0] == i_query[15:0]);
        end
    end
endmodule
